@@ hdl/wfys_pkg.sv @@
// Shared types, constants and helper functions of the weighted shuffle engine.
package wfys_pkg;

    localparam int C_MAX_MEMBERS = 64;
    localparam int C_CNT_W       = 7;
    localparam int C_SUM_W       = 10;
    localparam int C_WORD_BITS   = 32;
    localparam logic [3:0] C_MAX_WEIGHT = 4'd15;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_START = 2'd1,
        OP_WORD  = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    // Number of random bits one uniform swap takes for a given remaining count.
    function automatic logic [2:0] bits_for(input logic [C_CNT_W-1:0] remaining);
        logic [2:0] nb;
        if (remaining > 7'd63)      nb = 3'd7;
        else if (remaining > 7'd31) nb = 3'd6;
        else if (remaining > 7'd15) nb = 3'd5;
        else if (remaining > 7'd7)  nb = 3'd4;
        else if (remaining > 7'd3)  nb = 3'd3;
        else if (remaining > 7'd1)  nb = 3'd2;
        else                        nb = 3'd1;
        return nb;
    endfunction

    // Raw weight to stored weight: zero becomes one, large values saturate.
    function automatic logic [3:0] clamp_weight(input logic [7:0] raw);
        logic [3:0] w;
        if (raw == 8'd0)                 w = 4'd1;
        else if (raw > {4'd0, C_MAX_WEIGHT}) w = C_MAX_WEIGHT;
        else                             w = raw[3:0];
        return w;
    endfunction

endpackage

@@ hdl/wfys_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module wfys_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/wfys_div.sv @@
// Bit-serial restoring divider that returns the remainder of a 32-bit word.
module wfys_div
    import wfys_pkg::*;
#(
    parameter int SUM_W = C_SUM_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [31:0]      i_dividend,
    input  logic [SUM_W-1:0] i_divisor,
    output logic             o_done,
    output logic [SUM_W-1:0] o_rem
);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [4:0]       r_cnt, n_cnt;
    logic [31:0]      r_num, n_num;
    logic [SUM_W-1:0] r_rem, n_rem;
    logic [SUM_W-1:0] r_div, n_div;
    logic [SUM_W:0]   trial;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_rem  = r_rem;
        n_div  = r_div;
        trial  = {r_rem, r_num[31]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 5'd31;
            n_num  = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_div}) begin
                trial = trial - {1'b0, r_div};
            end
            n_rem = trial[SUM_W-1:0];
            n_num = {r_num[30:0], 1'b0};
            n_cnt = r_cnt - 5'd1;
            if (r_cnt == 5'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_num <= n_num;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

@@ hdl/weighted_fisher_yates_shuffle_top.sv @@
// Top level of the weighted shuffle engine: control sequencer around two RAMs.
//
// Usage. Input transactions (i_valid/o_ready) carry an operation code:
// load appends one member weight (clamped to 1..15, ignored while shuffling
// or once MAX_MEMBERS members are loaded), start sets the order to identity
// and arms a shuffle, and a random word advances the shuffle. Output
// transactions (o_valid/i_ready) carry one member index each; the whole
// permutation is sent in order, with o_is_last on its final member.
// The block works on one input transaction at a time: o_ready is high only
// while the sequencer is idle. A start runs an initialization sweep over
// the order RAM. A weighted word makes two walks through the order and
// weight RAMs over the remaining members, with the bit-serial divider
// between them, and then a swap. A uniform word does swaps, each bounded
// by the read-modify-write of the order RAM. The output register decouples
// the receiver: a stall holds the current member and pauses the emit sweep
// only, and the last member may wait while new input is already taken.
// Reset clears the member count and all control state; RAM contents are not
// cleared, since every entry is written before it is read.
module weighted_fisher_yates_shuffle_top
    import wfys_pkg::*;
#(
    parameter int MAX_MEMBERS = C_MAX_MEMBERS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_weight,
    input  logic [31:0] i_random_word,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [5:0]  o_member_index,
    output logic        o_is_last
);

    localparam int AW    = $clog2(MAX_MEMBERS);
    localparam int SUM_W = $clog2(MAX_MEMBERS * 15 + 1);

    typedef enum logic [14:0] {
        S_IDLE    = 15'b000000000000001,
        S_INIT    = 15'b000000000000010,
        S_WALK_RD = 15'b000000000000100,
        S_WALK_WT = 15'b000000000001000,
        S_WALK_AC = 15'b000000000010000,
        S_DSTART  = 15'b000000000100000,
        S_DIV     = 15'b000000001000000,
        S_UNI     = 15'b000000010000000,
        S_SWP_RA  = 15'b000000100000000,
        S_SWP_RB  = 15'b000001000000000,
        S_SWP_WA  = 15'b000010000000000,
        S_SWP_WB  = 15'b000100000000000,
        S_CHK     = 15'b001000000000000,
        S_EMIT_RD = 15'b010000000000000,
        S_EMIT_LD = 15'b100000000000000
    } t_state;

    t_state r_state, n_state;

    logic [C_CNT_W-1:0] r_count, n_count;
    logic [C_CNT_W-1:0] r_pos, n_pos;
    logic [C_CNT_W-1:0] r_k, n_k;
    logic [C_CNT_W-1:0] r_j, n_j;
    logic               r_wmode, n_wmode;
    logic               r_shuf, n_shuf;
    logic               r_chk, n_chk;
    logic               r_pass, n_pass;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic [SUM_W-1:0]   r_sel, n_sel;
    logic [31:0]        r_word, n_word;
    logic [5:0]         r_used, n_used;
    logic [AW-1:0]      r_sa, n_sa;
    logic [AW-1:0]      r_sb, n_sb;
    logic [AW-1:0]      r_va, n_va;
    logic [AW-1:0]      r_out, n_out;
    logic               r_last, n_last;
    logic               r_ovld, n_ovld;

    logic          ord_we;
    logic [AW-1:0] ord_waddr, ord_wdata, ord_raddr, ord_rdata;
    logic          wt_we;
    logic [AW-1:0] wt_waddr, wt_raddr;
    logic [3:0]    wt_wdata, wt_rdata;
    logic          div_start, div_done;
    logic [SUM_W-1:0] div_rem;

    logic [C_CNT_W-1:0] uni_rem, uni_val, uni_idx;
    logic [2:0]         uni_nb;
    logic [6:0]         uni_mask;
    logic [SUM_W-1:0]   w_ext;

    wfys_ram #(.WIDTH(AW), .DEPTH(MAX_MEMBERS)) u_order_ram (
        .i_clk   (i_clk),
        .i_we    (ord_we),
        .i_waddr (ord_waddr),
        .i_wdata (ord_wdata),
        .i_raddr (ord_raddr),
        .o_rdata (ord_rdata)
    );

    wfys_ram #(.WIDTH(4), .DEPTH(MAX_MEMBERS)) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (wt_we),
        .i_waddr (wt_waddr),
        .i_wdata (wt_wdata),
        .i_raddr (wt_raddr),
        .o_rdata (wt_rdata)
    );

    wfys_div #(.SUM_W(SUM_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_word),
        .i_divisor  ((r_sum == '0) ? SUM_W'(1) : r_sum),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // Uniform step: draw nb bits, reduce once modulo the remaining count.
    always_comb begin
        uni_rem  = r_count - r_pos;
        uni_nb   = bits_for(uni_rem);
        uni_mask = 7'((8'd1 << uni_nb) - 8'd1);
        uni_val  = r_word[6:0] & uni_mask;
        uni_idx  = (uni_val >= uni_rem) ? (uni_val - uni_rem) : uni_val;
        w_ext    = SUM_W'(wt_rdata);
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_pos   = r_pos;
        n_k     = r_k;
        n_j     = r_j;
        n_wmode = r_wmode;
        n_shuf  = r_shuf;
        n_chk   = r_chk;
        n_pass  = r_pass;
        n_sum   = r_sum;
        n_sel   = r_sel;
        n_word  = r_word;
        n_used  = r_used;
        n_sa    = r_sa;
        n_sb    = r_sb;
        n_va    = r_va;
        n_out   = r_out;
        n_last  = r_last;
        n_ovld  = r_ovld;

        ord_we    = 1'b0;
        ord_waddr = r_sa;
        ord_wdata = ord_rdata;
        ord_raddr = r_k[AW-1:0];
        wt_we     = 1'b0;
        wt_waddr  = r_count[AW-1:0];
        wt_wdata  = clamp_weight(i_weight);
        wt_raddr  = r_k[AW-1:0];
        div_start = 1'b0;

        // The output register drains on its own.
        if (r_ovld && i_ready) begin
            n_ovld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (t_op'(i_operation))
                        OP_LOAD: begin
                            if (!r_shuf && (r_count < C_CNT_W'(MAX_MEMBERS))) begin
                                wt_we   = 1'b1;
                                n_count = r_count + 7'd1;
                            end
                        end
                        OP_START: begin
                            n_k     = '0;
                            n_chk   = 1'b0;
                            n_wmode = 1'b0;
                            n_shuf  = 1'b0;
                            n_state = S_INIT;
                        end
                        OP_WORD: begin
                            if (r_shuf) begin
                                n_word = i_random_word;
                                n_used = '0;
                                if (r_wmode) begin
                                    n_pass  = 1'b0;
                                    n_sum   = '0;
                                    n_j     = r_pos;
                                    n_state = S_WALK_RD;
                                end else begin
                                    n_state = S_UNI;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_INIT: begin
                // Write identity order and check each weight in the following cycle.
                n_chk = 1'b0;
                if (r_k < r_count) begin
                    ord_we    = 1'b1;
                    ord_waddr = r_k[AW-1:0];
                    ord_wdata = r_k[AW-1:0];
                    n_k       = r_k + 7'd1;
                    n_chk     = 1'b1;
                end
                if (r_chk && (wt_rdata != 4'd1)) begin
                    n_wmode = 1'b1;
                end
                if ((r_k >= r_count) && !r_chk) begin
                    n_pos = '0;
                    n_k   = '0;
                    if (r_count <= 7'd1) begin
                        n_state = S_EMIT_RD;
                    end else begin
                        n_shuf  = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            S_WALK_RD: begin
                if (r_j < r_count) begin
                    ord_raddr = r_j[AW-1:0];
                    n_state   = S_WALK_WT;
                end else if (!r_pass) begin
                    n_state = S_DSTART;
                end else begin
                    n_sa    = r_pos[AW-1:0];
                    n_sb    = r_pos[AW-1:0];
                    n_state = S_SWP_RA;
                end
            end
            S_WALK_WT: begin
                wt_raddr = ord_rdata;
                n_state  = S_WALK_AC;
            end
            S_WALK_AC: begin
                if (!r_pass) begin
                    n_sum   = r_sum + w_ext;
                    n_j     = r_j + 7'd1;
                    n_state = S_WALK_RD;
                end else if (r_sel < w_ext) begin
                    n_sa    = r_pos[AW-1:0];
                    n_sb    = r_j[AW-1:0];
                    n_state = S_SWP_RA;
                end else begin
                    n_sel   = r_sel - w_ext;
                    n_j     = r_j + 7'd1;
                    n_state = S_WALK_RD;
                end
            end
            S_DSTART: begin
                div_start = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    n_sel   = div_rem;
                    n_pass  = 1'b1;
                    n_j     = r_pos;
                    n_state = S_WALK_RD;
                end
            end
            S_UNI: begin
                if (((r_pos + 7'd1) < r_count)
                        && (6'(r_used + 6'(uni_nb)) <= 6'(C_WORD_BITS))) begin
                    n_sa    = AW'(r_count - 7'd1 - r_pos);
                    n_sb    = uni_idx[AW-1:0];
                    n_word  = r_word >> uni_nb;
                    n_used  = 6'(r_used + 6'(uni_nb));
                    n_state = S_SWP_RA;
                end else begin
                    n_state = S_CHK;
                end
            end
            S_SWP_RA: begin
                ord_raddr = r_sa;
                n_state   = S_SWP_RB;
            end
            S_SWP_RB: begin
                ord_raddr = r_sb;
                n_va      = ord_rdata;
                n_state   = S_SWP_WA;
            end
            S_SWP_WA: begin
                ord_we    = 1'b1;
                ord_waddr = r_sa;
                ord_wdata = ord_rdata;
                n_state   = S_SWP_WB;
            end
            S_SWP_WB: begin
                ord_we    = 1'b1;
                ord_waddr = r_sb;
                ord_wdata = r_va;
                n_pos     = r_pos + 7'd1;
                n_state   = r_wmode ? S_CHK : S_UNI;
            end
            S_CHK: begin
                if ((r_pos + 7'd1) >= r_count) begin
                    n_shuf  = 1'b0;
                    n_k     = '0;
                    n_state = S_EMIT_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT_RD: begin
                if (r_k >= r_count) begin
                    n_state = S_IDLE;
                end else if (!r_ovld) begin
                    ord_raddr = r_k[AW-1:0];
                    n_state   = S_EMIT_LD;
                end
            end
            S_EMIT_LD: begin
                n_out   = ord_rdata;
                n_last  = ((r_k + 7'd1) == r_count);
                n_ovld  = 1'b1;
                n_k     = r_k + 7'd1;
                n_state = S_EMIT_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pos   <= '0;
            r_wmode <= 1'b0;
            r_shuf  <= 1'b0;
            r_chk   <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pos   <= n_pos;
            r_wmode <= n_wmode;
            r_shuf  <= n_shuf;
            r_chk   <= n_chk;
            r_ovld  <= n_ovld;
        end
        r_k    <= n_k;
        r_j    <= n_j;
        r_pass <= n_pass;
        r_sum  <= n_sum;
        r_sel  <= n_sel;
        r_word <= n_word;
        r_used <= n_used;
        r_sa   <= n_sa;
        r_sb   <= n_sb;
        r_va   <= n_va;
        r_out  <= n_out;
        r_last <= n_last;
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_ovld;
    assign o_member_index = 6'(r_out);
    assign o_is_last      = r_last;

    // A shuffle is only armed with at least two members.
    a_shuf_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_shuf |-> (r_count >= 7'd2))
        else $error("shuffle armed with fewer than two members");

    // The step position never runs past the loaded members while shuffling.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_shuf |-> (r_pos < r_count))
        else $error("step position beyond member count");

    // The divider only finishes while the sequencer waits for it.
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider result arrived outside the divide state");

    // A new result is only loaded by the emit sweep.
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovld) |-> ($past(r_state) == S_EMIT_LD))
        else $error("output register loaded outside the emit sweep");

endmodule
